/* src/assert_macros.svh */
// assertion macros for the rtl of the divisible subarray counter, included by divisible_subarray_counter_unit
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsc assertion failed");

`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsc assertion failed");

`else

`define DSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define DSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/dsc_pkg.sv */
// package of the divisible subarray counter: sizes, widths and state codes
// used by dsc_mod and divisible_subarray_counter_unit
package dsc_pkg;

  localparam int MaxMod = 4096;
  localparam int MaxLen = 65536;

  localparam int ElemW  = 20;
  localparam int ModW   = 13;
  localparam int TotW   = 32;
  localparam int ResW   = $clog2(MaxMod);
  localparam int SumW   = ElemW + 1;
  localparam int CntW   = $clog2(MaxLen + 2);
  localparam int ItemW  = $clog2(MaxLen + 1);
  localparam int StepW  = $clog2(SumW);
  localparam int InBytesW  = ((ElemW + 7) / 8) * 8;
  localparam int OutBytesW = ((TotW + 7) / 8) * 8;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_RD    = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

endpackage

/* src/divisible_subarray_counter_unit.sv */
// Divisible subarray counter. Each accepted word carries one non-negative element; the
// block returns one word with the running number of contiguous subarrays whose sum is a
// multiple of the configured modulus k (0 acts as 1, values above 4096 act as 4096).
// An element passes from acceptance to the result register through the bit-serial modulo
// unit (one step per bit of the 21-bit prefix sum, which is formed as the word is
// accepted), then through the states that take the residue, read the residue histogram
// ram, update it and load the output. The block takes no new element until the output
// is loaded, which waits while an earlier result is not yet taken. After reset a clearing
// pass writes every histogram entry before the first element is accepted; modulus writes
// are taken throughout.
// After 65536 elements the sequence is full and further elements return the held total.
// Depends on dsc_pkg, dsc_mod, dsc_ram and assert_macros.svh.
`include "assert_macros.svh"

module divisible_subarray_counter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsc_pkg::ModW-1:0]      cfg_wdata_i,     // modulus
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dsc_pkg::InBytesW-1:0]  s_axis_tdata,    // element, zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dsc_pkg::OutBytesW-1:0] m_axis_tdata     // total
);
  import dsc_pkg::*;

  state_e           state_q, state_d;
  logic [ModW-1:0]  modulus_q;
  logic [ResW-1:0]  residue_q, residue_d;
  logic [TotW-1:0]  total_q, total_d;
  logic [ItemW-1:0] items_q, items_d;
  logic [ResW-1:0]  clr_q, clr_d;
  logic             ovalid_q, ovalid_d;
  logic [TotW-1:0]  odata_q, odata_d;

  logic [ModW-1:0]  k_eff;
  logic             mod_start;
  logic [SumW-1:0]  mod_sum;
  logic             mod_done;
  logic [ResW-1:0]  mod_rem;

  logic             ram_we, ram_re;
  logic [ResW-1:0]  ram_waddr;
  logic [CntW-1:0]  ram_wdata, ram_rdata;
  logic [TotW:0]    tot_sum;
  logic             accept;

  always_comb begin
    if (modulus_q == '0) begin
      k_eff = ModW'(1);
    end else if (modulus_q > ModW'(MaxMod)) begin
      k_eff = ModW'(MaxMod);
    end else begin
      k_eff = modulus_q;
    end
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign mod_sum   = SumW'(residue_q) + SumW'(s_axis_tdata[ElemW-1:0]);
  assign mod_start = accept && (items_q != ItemW'(MaxLen));
  assign tot_sum   = {1'b0, total_q} + (TotW + 1)'(ram_rdata);

  dsc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_sum),
    .divisor_i  (k_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  dsc_ram #(
    .Width (CntW),
    .Depth (MaxMod)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (residue_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    residue_d     = residue_q;
    total_d       = total_q;
    items_d       = items_q;
    clr_d         = clr_q;
    ovalid_d      = ovalid_q;
    odata_d       = odata_q;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = residue_q;
    ram_wdata     = ram_rdata + 1'b1;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // residue zero stands for the empty prefix
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? CntW'(1) : '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (items_q == ItemW'(MaxLen)) begin
            state_d = ST_OUT;
          end else begin
            items_d = items_q + 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          residue_d = mod_rem;
          state_d   = ST_RD;
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        ram_we  = 1'b1;
        total_d = tot_sum[TotW] ? '1 : tot_sum[TotW-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = total_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      modulus_q <= ModW'(1);
      residue_q <= '0;
      total_q   <= '0;
      items_q   <= '0;
      clr_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      residue_q <= residue_d;
      total_q   <= total_d;
      items_q   <= items_d;
      clr_q     <= clr_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = OutBytesW'(odata_q);

  `DSC_ASSERT_SAME(a_res_below_k, clk_i, rst_ni, state_q == ST_UPD, {1'b0, residue_q} < k_eff)
  `DSC_ASSERT_SAME(a_items_bound, clk_i, rst_ni, 1'b1, items_q <= ItemW'(MaxLen))
  `DSC_ASSERT_NEXT(a_total_grows, clk_i, rst_ni, state_q == ST_UPD, total_q >= $past(total_q))
  `DSC_ASSERT_SAME(a_no_div_idle, clk_i, rst_ni, mod_done, state_q == ST_DIV)

endmodule

/* src/dsc_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module dsc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dsc_mod.sv */
// bit-serial restoring reduction of the prefix sum modulo k, one bit a cycle
// depends on dsc_pkg
module dsc_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dsc_pkg::SumW-1:0]  dividend_i,
  input  logic [dsc_pkg::ModW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [dsc_pkg::ResW-1:0]  rem_o
);
  import dsc_pkg::*;

  logic [SumW-1:0]  shf_q, shf_d;
  logic [ModW-1:0]  rem_q, rem_d;
  logic [ModW-1:0]  k_q, k_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ModW:0]    trial;

  always_comb begin
    shf_d  = shf_q;
    rem_d  = rem_q;
    k_d    = k_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, shf_q[SumW-1]};
    if (start_i) begin
      shf_d  = dividend_i;
      rem_d  = '0;
      k_d    = divisor_i;
      step_d = StepW'(SumW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      shf_d = {shf_q[SumW-2:0], 1'b0};
      if (trial >= {1'b0, k_q}) begin
        rem_d = ModW'(trial - {1'b0, k_q});
      end else begin
        rem_d = ModW'(trial);
      end
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    k_q   <= k_d;
  end

  // remainder is below k, which never exceeds the table depth
  assign done_o = done_q;
  assign rem_o  = rem_q[ResW-1:0];

endmodule
